// File: src/spmf_pkg.sv
// Package for the strict priority multi-level queue.
// Holds the transaction payload types, command and status codes and the
// controller-to-datapath command and status groups. Depends on nothing.
`default_nettype none

package spmf_pkg;

  localparam int MAX_LEVELS    = 8;
  localparam int QUEUE_DEPTH   = 16;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int CMD_W    = 2;
  localparam int PRIO_W   = 4;
  localparam int CFG_W    = 4;
  localparam int STATUS_W = 2;
  localparam int LCNT_W   = 5;
  localparam int TCNT_W   = 8;

  localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [PRIO_W-1:0]        priority_req;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [PAYLOAD_WIDTH-1:0] item;
    logic                     item_valid;
    logic [STATUS_W-1:0]      status;
    logic [LCNT_W-1:0]        level_count;
    logic [TCNT_W-1:0]        total_count;
    logic                     all_empty;
  } res_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic finish;
    logic rc_clear;
    logic rc_step;
  } dp_cmd_t;

  typedef struct packed {
    logic rc_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: src/spmf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the entry store of the queue. Depends on nothing.
`default_nettype none

module spmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/spmf_ctrl.sv
// Controller state machine of the strict priority multi-level queue.
// Sequences each transaction and the recount after a level register write.
// Depends on spmf_pkg.
`default_nettype none

module spmf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              cfg_we,
  input  wire spmf_pkg::dp_stat_t stat,
  output logic                   busy,
  output logic                   done,
  output spmf_pkg::dp_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_FINISH  = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_RECOUNT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       open;

  assign open = (state == ST_IDLE) || (state == ST_DONE);
  assign busy = !open || cfg_we;
  assign done = (state == ST_DONE);

  assign cmd.capture  = start && !busy;
  assign cmd.execute  = (state == ST_EXEC);
  assign cmd.finish   = (state == ST_FINISH);
  assign cmd.rc_clear = open && cfg_we;
  assign cmd.rc_step  = (state == ST_RECOUNT);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_DONE: begin
        if (cfg_we) begin
          state_next = ST_RECOUNT;
        end else if (start) begin
          state_next = ST_EXEC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EXEC: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_DONE;
      end
      ST_RECOUNT: begin
        if (stat.rc_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: src/spmf_datapath.sv
// Datapath of the strict priority multi-level queue: level register, per-level
// pointers and fill counts, running total, priority encoder and entry store.
// Depends on spmf_pkg and spmf_ram.
`default_nettype none

module spmf_datapath #(
  parameter int MAX_LEVELS  = spmf_pkg::MAX_LEVELS,
  parameter int QUEUE_DEPTH = spmf_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire spmf_pkg::dp_cmd_t           cmd,
  output spmf_pkg::dp_stat_t               stat,
  input  wire logic                        cfg_we,
  input  wire logic [spmf_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire spmf_pkg::req_t              request,
  output spmf_pkg::res_t                   result
);

  localparam int LIDX_W = $clog2(MAX_LEVELS);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W  = $clog2(MAX_LEVELS * QUEUE_DEPTH + 1);
  localparam int NL_W   = $clog2(MAX_LEVELS + 1);
  localparam int CMP_W  = (NL_W > spmf_pkg::PRIO_W) ? NL_W : spmf_pkg::PRIO_W;
  localparam int ADDR_W = LIDX_W + PTR_W;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  spmf_pkg::req_t              req_q;
  logic [spmf_pkg::CFG_W-1:0]  levels;
  logic [FILL_W-1:0]           fill [MAX_LEVELS];
  logic [PTR_W-1:0]            head [MAX_LEVELS];
  logic [PTR_W-1:0]            tail [MAX_LEVELS];
  logic [TOT_W-1:0]            total;
  logic [LIDX_W-1:0]           rc_idx;
  logic                        prio_ok_q;
  logic [LIDX_W-1:0]           lvl_q;
  logic                        valid_q;
  logic [spmf_pkg::STATUS_W-1:0] status_q;

  logic [CMP_W-1:0]            cfg_ext;
  logic [CMP_W-1:0]            nlev;
  logic [CMP_W-1:0]            prio_ext;
  logic                        prio_ok;
  logic [LIDX_W-1:0]           lvl;
  logic [MAX_LEVELS-1:0]       occ;
  logic                        found;
  logic [LIDX_W-1:0]           sel;
  logic                        full;
  logic                        is_read;
  logic                        do_enq;
  logic                        do_read;
  logic                        do_pop;
  logic [spmf_pkg::STATUS_W-1:0] status_now;

  logic [ADDR_W-1:0]                  waddr;
  logic [ADDR_W-1:0]                  raddr;
  logic [spmf_pkg::PAYLOAD_WIDTH-1:0] rdata;

  assign cfg_ext  = CMP_W'(levels);
  assign prio_ext = CMP_W'(req_q.priority_req);

  always_comb begin
    if (levels == '0) begin
      nlev = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_LEVELS)) begin
      nlev = CMP_W'(MAX_LEVELS);
    end else begin
      nlev = cfg_ext;
    end
  end

  assign prio_ok = (prio_ext != '0) && (prio_ext <= nlev);
  assign lvl     = LIDX_W'(prio_ext - CMP_W'(1));

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      occ[i] = (fill[i] != '0) && (CMP_W'(i) < nlev);
      if (occ[i]) begin
        found = 1'b1;
        sel   = LIDX_W'(i);
      end
    end
  end

  assign full    = (fill[lvl] == FILL_W'(QUEUE_DEPTH));
  assign is_read = (req_q.cmd inside {spmf_pkg::CMD_PEEK, spmf_pkg::CMD_REMOVE});
  assign do_enq  = cmd.execute && (req_q.cmd == spmf_pkg::CMD_ENQUEUE) && prio_ok && !full;
  assign do_read = cmd.execute && is_read && found;
  assign do_pop  = do_read && (req_q.cmd == spmf_pkg::CMD_REMOVE);

  always_comb begin
    case (req_q.cmd)
      spmf_pkg::CMD_ENQUEUE: begin
        if (!prio_ok) begin
          status_now = spmf_pkg::STATUS_RANGE;
        end else if (full) begin
          status_now = spmf_pkg::STATUS_FULL;
        end else begin
          status_now = spmf_pkg::STATUS_OK;
        end
      end
      spmf_pkg::CMD_PEEK, spmf_pkg::CMD_REMOVE: begin
        if (!found) begin
          status_now = spmf_pkg::STATUS_EMPTY;
        end else if (prio_ok) begin
          status_now = spmf_pkg::STATUS_OK;
        end else begin
          status_now = spmf_pkg::STATUS_RANGE;
        end
      end
      default: begin
        status_now = prio_ok ? spmf_pkg::STATUS_OK : spmf_pkg::STATUS_RANGE;
      end
    endcase
  end

  assign waddr = {lvl, tail[lvl]};
  assign raddr = {sel, head[sel]};

  assign stat.rc_last = (rc_idx == LIDX_W'(MAX_LEVELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= spmf_pkg::LEVELS_RESET;
      total  <= '0;
      rc_idx <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        fill[i] <= '0;
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        levels <= cfg_wdata;
      end
      if (cmd.rc_clear) begin
        total  <= '0;
        rc_idx <= '0;
      end else if (cmd.rc_step) begin
        if (CMP_W'(rc_idx) < nlev) begin
          total <= total + TOT_W'(fill[rc_idx]);
        end
        rc_idx <= rc_idx + LIDX_W'(1);
      end else if (do_enq) begin
        tail[lvl] <= next_ptr(tail[lvl]);
        fill[lvl] <= fill[lvl] + FILL_W'(1);
        total     <= total + TOT_W'(1);
      end else if (do_pop) begin
        head[sel] <= next_ptr(head[sel]);
        fill[sel] <= fill[sel] - FILL_W'(1);
        total     <= total - TOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= request;
    end
    if (cmd.execute) begin
      prio_ok_q <= prio_ok;
      lvl_q     <= lvl;
      valid_q   <= is_read && found;
      status_q  <= status_now;
    end
    if (cmd.finish) begin
      result.item        <= valid_q ? rdata : '0;
      result.item_valid  <= valid_q;
      result.status      <= status_q;
      result.level_count <= prio_ok_q ? spmf_pkg::LCNT_W'(fill[lvl_q]) : '0;
      result.total_count <= spmf_pkg::TCNT_W'(total);
      result.all_empty   <= (total == '0);
    end
  end

  spmf_ram #(
    .WIDTH (spmf_pkg::PAYLOAD_WIDTH),
    .DEPTH (2 ** ADDR_W)
  ) u_entry_store (
    .clk   (clk),
    .we    (do_enq),
    .waddr (waddr),
    .wdata (req_q.payload),
    .re    (do_read),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// File: src/strict_priority_multi_fifo.sv
// Strict priority multi-level queue, top level: controller and datapath.
// A transaction accepted at one edge passes through the execute and finish states and
// has its result on done for one cycle; the receiver cannot stall, and the next
// transaction may be accepted while done is high, not before. A level register
// write while idle or done holds busy while the total is recounted.
// Synchronous reset empties all queues and sets eight levels; entries are kept.
`default_nettype none

module strict_priority_multi_fifo #(
  parameter int MAX_LEVELS  = spmf_pkg::MAX_LEVELS,
  parameter int QUEUE_DEPTH = spmf_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire spmf_pkg::req_t             request,
  output logic                            done,
  output spmf_pkg::res_t                  result,
  input  wire logic                       cfg_we,
  input  wire logic [spmf_pkg::CFG_W-1:0] cfg_wdata
);

  spmf_pkg::dp_cmd_t  dp_cmd;
  spmf_pkg::dp_stat_t dp_stat;

  spmf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_we (cfg_we),
    .stat   (dp_stat),
    .busy   (busy),
    .done   (done),
    .cmd    (dp_cmd)
  );

  spmf_datapath #(
    .MAX_LEVELS  (MAX_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (request),
    .result    (result)
  );

  a_result_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("Result did not follow an accepted transaction.");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Busy low while a transaction is in progress.");

  a_single_strobe : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Result strobe held for more than one cycle.");

endmodule

`default_nettype wire
